FILE: sv/v3au_pkg.sv
// Shared types, codes and helpers for the three-component vector ALU.
package v3au_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_DOT   = 3'd4;
    localparam logic [2:0] OP_LEN   = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;

    typedef enum logic [2:0] {
        K_ADD, K_SUB, K_SCALE, K_DIV, K_DOT, K_LEN, K_NORM, K_NONE
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             div_zero;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PROD, ST_SQINIT, ST_ROOT, ST_DIVIDE, ST_FINISH
    } bstate_t;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } sat_t;

    // Clip a wide signed value to the 32-bit signed range.
    function automatic sat_t sat66(logic signed [65:0] v);
        sat_t r;
        if (v > 66'sd2147483647) begin
            r.val  = 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end else if (v < -66'sd2147483648) begin
            r.val  = 32'h8000_0000;
            r.clip = 1'b1;
        end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/v3au_front.sv
// Front end: decodes the operation and flags a zero divisor.
module v3au_front
    import v3au_pkg::*;
(
    input  logic [2:0]  operation,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] scalar_in,
    output item_t       item
);

    kind_t kind;

    always_comb
    begin
        case (operation)
            OP_ADD:   kind = K_ADD;
            OP_SUB:   kind = K_SUB;
            OP_SCALE: kind = K_SCALE;
            OP_DIV:   kind = K_DIV;
            OP_DOT:   kind = K_DOT;
            OP_LEN:   kind = K_LEN;
            OP_NORM:  kind = K_NORM;
            default:  kind = K_NONE;
        endcase
    end

    assign item.kind     = kind;
    assign item.div_zero = (kind == K_DIV) && (scalar_in == 32'd0);
    assign item.a        = {a_z, a_y, a_x};
    assign item.b        = {b_z, b_y, b_x};
    assign item.s        = scalar_in;

endmodule

FILE: sv/v3au_fifo.sv
// Short queue between the front end and the execution back end.
module v3au_fifo
    import v3au_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    item_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/v3au_back.sv
// Back end: multipliers, iterative square root and three divider lanes.
module v3au_back
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  item_t       q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] r_x,
    output logic [31:0] r_y,
    output logic [31:0] r_z,
    output logic [31:0] scalar_out,
    output logic        divide_fault,
    output logic        saturated
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    bstate_t state_reg, state_next;
    logic    out_valid_reg, out_valid_next;

    item_t              w_reg, w_next;
    logic signed [63:0] prod_reg [3];
    logic signed [63:0] prod_next [3];
    logic [63:0]        rad_reg, rad_next;
    logic [31:0]        root_reg, root_next;
    logic [33:0]        srem_reg, srem_next;
    logic [32:0]        len_reg, len_next;
    logic [32:0]        ddiv_reg, ddiv_next;
    logic [33:0]        drem_reg [3];
    logic [33:0]        drem_next [3];
    logic [DW-1:0]      dquo_reg [3];
    logic [DW-1:0]      dquo_next [3];
    logic               neg_reg [3];
    logic               neg_next [3];
    logic               fault_reg, fault_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    logic [31:0] r_x_reg, r_y_reg, r_z_reg, sc_reg;
    logic        fault_out_reg, clip_out_reg;
    logic        load_out;

    // finish-stage results
    sat_t res_sat [4];
    logic signed [65:0] res_t [4];

    logic [31:0] mag_a [3];
    logic [31:0] mag_s;
    logic [35:0] rem2, trial;
    logic [33:0] rem_sh [3];
    logic [32:0] len_fin;

    always_comb
    begin
        logic signed [65:0] half;
        logic signed [65:0] dsum;
        logic signed [65:0] q66;
        half = 66'sd1 <<< (FRAC_BITS - 1);
        dsum = {{2{prod_reg[0][63]}}, prod_reg[0]} + {{2{prod_reg[1][63]}}, prod_reg[1]}
             + {{2{prod_reg[2][63]}}, prod_reg[2]};
        for (int i = 0; i < 4; i++)
        begin
            res_t[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            q66 = {{(66-DW){1'b0}}, dquo_reg[i]};
            case (w_reg.kind)
                K_ADD:   res_t[i] = {{34{w_reg.a[i][31]}}, w_reg.a[i]}
                                  + {{34{w_reg.b[i][31]}}, w_reg.b[i]};
                K_SUB:   res_t[i] = {{34{w_reg.a[i][31]}}, w_reg.a[i]}
                                  - {{34{w_reg.b[i][31]}}, w_reg.b[i]};
                K_SCALE: res_t[i] = ($signed({{2{prod_reg[i][63]}}, prod_reg[i]}) + half)
                                  >>> FRAC_BITS;
                K_DIV, K_NORM:
                begin
                    if (!fault_reg)
                    begin
                        res_t[i] = neg_reg[i] ? -q66 : q66;
                    end
                end
                default: res_t[i] = '0;
            endcase
        end
        case (w_reg.kind)
            K_DOT:   res_t[3] = (dsum + half) >>> FRAC_BITS;
            K_LEN:   res_t[3] = {33'd0, len_reg};
            default: res_t[3] = '0;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            res_sat[i] = sat66(res_t[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a[i]  = w_reg.a[i][31] ? (~w_reg.a[i] + 32'd1) : w_reg.a[i];
            rem_sh[i] = {drem_reg[i][32:0], dquo_reg[i][DW-1]};
        end
        mag_s   = w_reg.s[31] ? (~w_reg.s + 32'd1) : w_reg.s;
        rem2    = {srem_reg, rad_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        len_fin = {1'b0, root_reg} + 33'(srem_reg > {2'b00, root_reg});
    end

    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        logic signed [31:0] x, y;
        state_next     = state_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        w_next         = w_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        len_next       = len_reg;
        ddiv_next      = ddiv_reg;
        fault_next     = fault_reg;
        cnt_next       = cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = prod_reg[i];
            drem_next[i] = drem_reg[i];
            dquo_next[i] = dquo_reg[i];
            neg_next[i]  = neg_reg[i];
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    w_next     = q_head;
                    fault_next = 1'b0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x = $signed(w_reg.a[i]);
                    case (w_reg.kind)
                        K_SCALE: y = $signed(w_reg.s);
                        K_DOT:   y = $signed(w_reg.b[i]);
                        default: y = $signed(w_reg.a[i]);
                    endcase
                    prod_next[i] = x * y;
                end
                case (w_reg.kind)
                    K_DIV:
                    begin
                        if (w_reg.div_zero)
                        begin
                            fault_next = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                drem_next[i] = '0;
                                dquo_next[i] = {mag_a[i], {FRAC_BITS{1'b0}}};
                                neg_next[i]  = w_reg.a[i][31] ^ w_reg.s[31];
                            end
                            ddiv_next  = {1'b0, mag_s};
                            cnt_next   = CW'(DW);
                            state_next = ST_DIVIDE;
                        end
                    end
                    K_LEN, K_NORM: state_next = ST_SQINIT;
                    default:       state_next = ST_FINISH;
                endcase
            end
            ST_SQINIT:
            begin
                rad_next   = 64'(prod_reg[0]) + 64'(prod_reg[1]) + 64'(prod_reg[2]);
                root_next  = '0;
                srem_next  = '0;
                cnt_next   = CW'(32);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (cnt_reg != '0)
                begin
                    if (rem2 >= trial)
                    begin
                        srem_next = 34'(rem2 - trial);
                        root_next = {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        srem_next = rem2[33:0];
                        root_next = {root_reg[30:0], 1'b0};
                    end
                    rad_next = {rad_reg[61:0], 2'b00};
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    len_next = len_fin;
                    if (w_reg.kind == K_LEN)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (len_fin == '0)
                    begin
                        fault_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            drem_next[i] = '0;
                            dquo_next[i] = {mag_a[i], {FRAC_BITS{1'b0}}};
                            neg_next[i]  = w_reg.a[i][31];
                        end
                        ddiv_next  = len_fin;
                        cnt_next   = CW'(DW);
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (rem_sh[i] >= {1'b0, ddiv_reg})
                        begin
                            drem_next[i] = rem_sh[i] - {1'b0, ddiv_reg};
                            dquo_next[i] = {dquo_reg[i][DW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_next[i] = rem_sh[i];
                            dquo_next[i] = {dquo_reg[i][DW-2:0], 1'b0};
                        end
                    end
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        len_reg   <= len_next;
        ddiv_reg  <= ddiv_next;
        fault_reg <= fault_next;
        cnt_reg   <= cnt_next;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= prod_next[i];
            drem_reg[i] <= drem_next[i];
            dquo_reg[i] <= dquo_next[i];
            neg_reg[i]  <= neg_next[i];
        end
        if (load_out)
        begin
            r_x_reg       <= res_sat[0].val;
            r_y_reg       <= res_sat[1].val;
            r_z_reg       <= res_sat[2].val;
            sc_reg        <= res_sat[3].val;
            fault_out_reg <= fault_reg;
            clip_out_reg  <= res_sat[0].clip | res_sat[1].clip
                           | res_sat[2].clip | res_sat[3].clip;
        end
    end

    assign out_valid    = out_valid_reg;
    assign r_x          = r_x_reg;
    assign r_y          = r_y_reg;
    assign r_z          = r_z_reg;
    assign scalar_out   = sc_reg;
    assign divide_fault = fault_out_reg;
    assign saturated    = clip_out_reg;

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_fault) |-> (!saturated && r_x == '0 && r_y == '0
                                         && r_z == '0 && scalar_out == '0))
        else $error("fault result not cleared");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (ddiv_reg != '0))
        else $error("divider running with zero divisor");

    a_finish_pop: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid && state_reg == ST_IDLE))
        else $error("result load did not raise out_valid");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && !q_empty))
        else $error("queue popped outside idle or while empty");

endmodule

FILE: sv/vec3_arith_unit_core.sv
// Top level of the three-component Q-format vector ALU.
//
// Input channel (in_valid/in_ready): one transfer carries an operation code,
// vectors a and b and a scalar. The front end decodes the code and pushes the
// item into a four-entry queue; in_ready is high whenever the queue has room,
// so items are taken while the back end is still busy with earlier ones.
// Output channel (out_valid/out_ready): one transfer per item, in order,
// from a result register.
//
// Back-end steps per item, from queue pop to result register load:
//   add, subtract, scale, dot and divide by zero: products, then finish
//   divide: products, divider lanes, finish; length: products, root set-up,
//   square root, finish; normalize: as length, with divider lanes before finish
// The square root (two bits a cycle) and the three restoring divider lanes
// (one quotient bit a cycle) are iterative; the back end runs one item at a
// time and pops the next item only after it loads the result of the last.
//
// Reset empties the queue and clears out_valid. If the receiver stalls, the
// result register holds, the back end waits in its last step and the queue
// fills up to four items before in_ready falls.
module vec3_arith_unit_core
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] scalar_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] r_x,
    output logic [31:0] r_y,
    output logic [31:0] r_z,
    output logic [31:0] scalar_out,
    output logic        divide_fault,
    output logic        saturated
);

    item_t front_item;
    item_t q_head;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  push;

    // accept whenever the queue has a free slot
    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    v3au_front u_front (
        .operation (operation),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .scalar_in (scalar_in),
        .item      (front_item)
    );

    v3au_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    v3au_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .r_x          (r_x),
        .r_y          (r_y),
        .r_z          (r_z),
        .scalar_out   (scalar_out),
        .divide_fault (divide_fault),
        .saturated    (saturated)
    );

endmodule

FILE: bench/vec3_arith_unit_core_test.sv
// Self-checking bench for the vec3_arith_unit_core vector ALU.
`timescale 1ns / 100ps

module vec3_arith_unit_core_test;
    import v3au_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 1500000;

    // code with no operation behind it
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // one input transfer
    typedef struct {
        logic [2:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz, s;
    } vec_req_t;

    // one output transfer
    typedef struct {
        logic [31:0] rx, ry, rz, sc;
        logic        fault, clip;
    } vec_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] r_x, r_y, r_z, scalar_out;
    logic        divide_fault, saturated;

    vec_req_t pending_reqs[$];
    vec_res_t expected_results[$];
    int       error_count;
    longint   cycle_count;
    bit       stim_done;
    bit       hold_off;      // sender paused until the result queue drains
    bit       quiet_phase;   // no idling on either side

    vec3_arith_unit_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .scalar_in(scalar_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z),
        .scalar_out(scalar_out),
        .divide_fault(divide_fault), .saturated(saturated)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor: fixed-point arithmetic on wide signed integers.
    // ---------------------------------------------------------------
    function automatic logic [31:0] clip32(longint signed v, ref logic clip);
        if (v > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor shift with round-half-up: (p + 2^(FB-1)) >>> FB, done on 128 bits
    function automatic longint signed round_shift(logic signed [127:0] p);
        logic signed [127:0] t;
        t = (p + (128'sd1 <<< (FB - 1))) >>> FB;
        return t[63:0];
    endfunction

    // Q-format quotient truncated toward zero
    function automatic longint signed q_divide(longint signed a, longint signed d);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 128'(a) <<< FB;
        q = n / 128'(d);
        return q[63:0];
    endfunction

    // integer square root of a 64-bit sum, rounded to nearest
    function automatic longint unsigned root_nearest(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'd1 << 34;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        // round up when v - r^2 > r
        if (v - r * r > r) r = r + 1;
        return r[63:0];
    endfunction

    function automatic vec_res_t vector_alu_result(vec_req_t q);
        vec_res_t            res;
        longint signed       a[3], b[3], v[3], s, sc;
        logic signed [127:0] acc;
        logic [127:0]        sq;
        longint unsigned     len;
        logic                has_vec, has_sc, clip;
        a[0] = longint'($signed(q.ax)); a[1] = longint'($signed(q.ay));
        a[2] = longint'($signed(q.az));
        b[0] = longint'($signed(q.bx)); b[1] = longint'($signed(q.by));
        b[2] = longint'($signed(q.bz));
        s = longint'($signed(q.s));
        v = '{0, 0, 0};
        sc = 0;
        has_vec = 1'b0;
        has_sc = 1'b0;
        clip = 1'b0;
        res.fault = 1'b0;
        case (q.op)
            OP_ADD, OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = (q.op == OP_ADD) ? a[i] + b[i] : a[i] - b[i];
                has_vec = 1'b1;
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = round_shift(128'(a[i]) * 128'(s));
                has_vec = 1'b1;
            end
            OP_DIV:
            begin
                if (s == 0) res.fault = 1'b1;
                else
                begin
                    for (int i = 0; i < 3; i++) v[i] = q_divide(a[i], s);
                    has_vec = 1'b1;
                end
            end
            OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += 128'(a[i]) * 128'(b[i]);
                sc = round_shift(acc);
                has_sc = 1'b1;
            end
            OP_LEN, OP_NORM:
            begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq += 128'(a[i] * a[i]);
                len = root_nearest(sq);
                if (q.op == OP_LEN)
                begin
                    sc = longint'(len);
                    has_sc = 1'b1;
                end
                else if (len == 0) res.fault = 1'b1;
                else
                begin
                    for (int i = 0; i < 3; i++) v[i] = q_divide(a[i], longint'(len));
                    has_vec = 1'b1;
                end
            end
            default: ;
        endcase
        res.rx = has_vec ? clip32(v[0], clip) : '0;
        res.ry = has_vec ? clip32(v[1], clip) : '0;
        res.rz = has_vec ? clip32(v[2], clip) : '0;
        res.sc = has_sc ? clip32(sc, clip) : '0;
        res.clip = clip;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return 32'(int'($urandom_range(0, 8)) - 4) << FB;
            4, 5: return 32'($signed($urandom) >>> $urandom_range(8, 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic [2:0] op, logic [31:0] ax, ay, az, bx, by, bz, s);
        vec_req_t q;
        q.op = op; q.ax = ax; q.ay = ay; q.az = az;
        q.bx = bx; q.by = by; q.bz = bz; q.s = s;
        pending_reqs.push_back(q);
    endtask

    task automatic add_random_req();
        logic [2:0] op;
        logic [31:0] s;
        op = ($urandom_range(0, 99) < 2) ? OP_UNUSED : 3'($urandom_range(0, 6));
        s = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_value();
        add_req(op, pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value(), s);
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    initial
    begin
        error_count = 0;
        stim_done   = 1'b0;
        hold_off    = 1'b0;
        quiet_phase = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, extremes, zero divisors, unused code
        add_req(OP_ADD, MAXV, MINV, ONE, ONE, MINV, ONE, 0);       // clip both ways
        add_req(OP_SUB, MINV, MAXV, 0, ONE, MINV, MINV, 0);
        add_req(OP_SCALE, ONE, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, 32'h0000_0001);
        add_req(OP_SCALE, MAXV, MINV, ONE, 0, 0, 0, MAXV);
        add_req(OP_SCALE, MINV, MINV, MAXV, 0, 0, 0, MINV);
        add_req(OP_DIV, ONE, MAXV, MINV, 0, 0, 0, 32'h0000_0001);
        add_req(OP_DIV, ONE, MINV, 3, 0, 0, 0, 32'hFFFF_FFFF);
        add_req(OP_DIV, ONE, ONE, ONE, 0, 0, 0, 0);                // divide by zero
        add_req(OP_DIV, 32'h0003_0000, 32'hFFFD_0000, 7, 0, 0, 0, 32'h0002_0000);
        add_req(OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0);
        add_req(OP_DOT, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0);
        add_req(OP_DOT, ONE, 32'h0000_8000, 0, 32'h0000_8000, 32'h0000_0001, 0, 0);
        add_req(OP_LEN, MINV, MINV, MINV, 0, 0, 0, 0);
        add_req(OP_LEN, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
        add_req(OP_LEN, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0);                     // zero vector
        add_req(OP_NORM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 1, 0, 0, 0, 0, 0, 0);                     // tiny length
        add_req(OP_NORM, MAXV, MINV, MAXV, 0, 0, 0, 0);
        add_req(OP_UNUSED, MAXV, MINV, ONE, ONE, ONE, ONE, ONE);   // unused code
        wait (pending_reqs.size() == 0);

        // sender holds off until every result is back
        hold_off = 1'b1;
        wait (expected_results.size() == 0);
        @(posedge clk);
        hold_off = 1'b0;

        for (int i = 0; i < 1330; i++)
        begin
            add_random_req();
            if (i == 400) quiet_phase = 1'b1;
            if (i == 600) quiet_phase = 1'b0;
            while (pending_reqs.size() > 8) @(posedge clk);
        end
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Driver: takes the head of pending_reqs, holds it until transfer.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= '0;
            a_x <= '0; a_y <= '0; a_z <= '0;
            b_x <= '0; b_y <= '0; b_z <= '0;
            scalar_in <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            // slot free: either load the next item or go idle
            if (in_valid && in_ready)
                expected_results.push_back(vector_alu_result(pending_reqs.pop_front()));
            if (pending_reqs.size() > 0 && !hold_off &&
                (quiet_phase || $urandom_range(0, 99) >= 8))
            begin
                in_valid  <= 1'b1;
                operation <= pending_reqs[0].op;
                a_x <= pending_reqs[0].ax; a_y <= pending_reqs[0].ay;
                a_z <= pending_reqs[0].az;
                b_x <= pending_reqs[0].bx; b_y <= pending_reqs[0].by;
                b_z <= pending_reqs[0].bz;
                scalar_in <= pending_reqs[0].s;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks every output transfer against the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        vec_res_t want;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result transfer (cycle %0d)", cycle_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (r_x !== want.rx) report_mismatch("r_x", r_x, want.rx);
                    if (r_y !== want.ry) report_mismatch("r_y", r_y, want.ry);
                    if (r_z !== want.rz) report_mismatch("r_z", r_z, want.rz);
                    if (scalar_out !== want.sc)
                        report_mismatch("scalar_out", scalar_out, want.sc);
                    if (divide_fault !== want.fault)
                        report_mismatch("divide_fault", 32'(divide_fault), 32'(want.fault));
                    if (saturated !== want.clip)
                        report_mismatch("saturated", 32'(saturated), 32'(want.clip));
                end
            end
            out_ready <= quiet_phase || ($urandom_range(0, 99) >= 8);
        end
    end

    // End of run and watchdog.
    initial
    begin
        wait (stim_done || cycle_count >= CYCLE_LIMIT);
        if (!stim_done)
            $display("vec3_arith_unit_core regression: fail");
        else if (error_count == 0 && expected_results.size() == 0)
            $display("vec3_arith_unit_core regression: pass");
        else
            $display("vec3_arith_unit_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/v3au_pkg.sv
sv/v3au_front.sv
sv/v3au_fifo.sv
sv/v3au_back.sv
sv/vec3_arith_unit_core.sv
bench/vec3_arith_unit_core_test.sv
